>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, off while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Check an implication on every rising clock edge, off while reset is low.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

`endif

>>> sv/mpq_pkg.sv
`default_nettype none

package mpq_pkg;

  // Default sizes
  localparam int unsigned CapacityDefault     = 128;
  localparam int unsigned PriorityBitsDefault = 8;

  // Operation codes
  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // Record payload carried with each priority
  typedef struct packed {
    logic [15:0] exam_id;
    logic [15:0] subject_id;
    logic [15:0] image_id;
    logic [7:0]  condition;
    logic [15:0] wait_time;
  } rec_t;

  // Broadcast control for the cell row
  typedef struct packed {
    logic ins;
    logic ext;
  } ctrl_t;

endpackage

`default_nettype wire

>>> sv/mpq_cell.sv
`default_nettype none

// One slot of the sorted row. Slots are kept in descending priority order,
// slot 0 first. On insert the slot keeps, takes the new record, or takes its
// left neighbor's record; on extract it takes its right neighbor's record.
module mpq_cell #(
  parameter int unsigned PrioBits = mpq_pkg::PriorityBitsDefault
) (
  input  wire                       clk_i,
  input  wire mpq_pkg::ctrl_t       ctrl_i,
  input  wire                       occupied_i,
  input  wire        [PrioBits-1:0] new_prio_i,
  input  wire mpq_pkg::rec_t        new_rec_i,
  input  wire                       left_gt_i,
  input  wire        [PrioBits-1:0] left_prio_i,
  input  wire mpq_pkg::rec_t        left_rec_i,
  input  wire        [PrioBits-1:0] right_prio_i,
  input  wire mpq_pkg::rec_t        right_rec_i,
  output logic                      gt_o,
  output logic       [PrioBits-1:0] prio_o,
  output mpq_pkg::rec_t             rec_o
);

  logic [PrioBits-1:0] prio_q, prio_d;
  mpq_pkg::rec_t       rec_q, rec_d;

  // New record goes ahead of this slot when the slot is free or lower
  assign gt_o = !occupied_i || (prio_q < new_prio_i);

  // Pick the next slot content
  always_comb begin
    prio_d = prio_q;
    rec_d  = rec_q;
    if (ctrl_i.ext) begin
      prio_d = right_prio_i;
      rec_d  = right_rec_i;
    end else if (ctrl_i.ins && gt_o) begin
      if (left_gt_i) begin
        prio_d = left_prio_i;
        rec_d  = left_rec_i;
      end else begin
        prio_d = new_prio_i;
        rec_d  = new_rec_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    rec_q  <= rec_d;
  end

  assign prio_o = prio_q;
  assign rec_o  = rec_q;

endmodule

`default_nettype wire

>>> sv/max_priority_queue_top.sv
`default_nettype none
`include "assert_macros.svh"

// Max-priority queue of exam records held in a row of sorting slots.
// Input channel (in_valid_i / in_ready_o): operation_i selects insert or
// extract; insert fields are ignored on extract. Output channel
// (out_valid_o / out_ready_i): one result per item with status, the
// extracted record (zero on insert or on an empty queue) and the
// occupancy after the operation.
// Every slot compares its priority against the incoming one and shifts in
// the same cycle: the result appears in the output register in the cycle
// after acceptance, and a new item can be taken in every cycle while the
// receiver keeps up (one item per cycle).
// Equal priorities leave in arrival order. Inserts into a full queue return
// status full; extracts from an empty queue return status empty.
// Reset clears the count and the output valid; slot contents need no reset.
// When the receiver stalls, the result holds in the output register and the
// input is not accepted until that result is taken.
module max_priority_queue_top #(
  parameter int unsigned CAPACITY      = mpq_pkg::CapacityDefault,
  parameter int unsigned PRIORITY_BITS = mpq_pkg::PriorityBitsDefault
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire         operation_i,
  input  wire  [7:0]  in_priority_i,
  input  wire  [15:0] in_exam_id_i,
  input  wire  [15:0] in_subject_id_i,
  input  wire  [15:0] in_image_id_i,
  input  wire  [7:0]  in_condition_i,
  input  wire  [15:0] in_wait_time_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [1:0]  status_o,
  output logic [7:0]  out_priority_o,
  output logic [15:0] out_exam_id_o,
  output logic [15:0] out_subject_id_o,
  output logic [15:0] out_image_id_o,
  output logic [7:0]  out_condition_o,
  output logic [15:0] out_wait_time_o,
  output logic [7:0]  occupancy_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  mpq_pkg::status_e status_q, status_d;
  logic [7:0]      out_prio_q, out_prio_d;
  mpq_pkg::rec_t   out_rec_q, out_rec_d;
  logic [7:0]      occ_q, occ_d;

  logic            in_acc;
  logic            is_full, is_empty;
  mpq_pkg::ctrl_t  ctrl;
  logic [PRIORITY_BITS-1:0] new_prio;
  logic [PRIORITY_BITS+7:0] new_prio_wide;
  logic [PRIORITY_BITS+7:0] head_prio_wide;
  logic [CntW+7:0]          occ_wide;
  mpq_pkg::rec_t            new_rec;

  logic [CAPACITY-1:0]      occupied;
  logic [CAPACITY-1:0]      gt;
  logic [PRIORITY_BITS-1:0] prio [CAPACITY];
  mpq_pkg::rec_t            rec  [CAPACITY];

  // Handshake: take an item when the output register is free or draining
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  assign is_full  = (count_q == CapCnt);
  assign is_empty = (count_q == '0);

  // Broadcast control to the row
  assign ctrl.ins = in_acc && (operation_i == mpq_pkg::OP_INSERT) && !is_full;
  assign ctrl.ext = in_acc && (operation_i == mpq_pkg::OP_EXTRACT) && !is_empty;

  // Keep the low priority bits of the incoming record
  assign new_prio_wide = {{PRIORITY_BITS{1'b0}}, in_priority_i};
  assign new_prio      = new_prio_wide[PRIORITY_BITS-1:0];
  assign new_rec       = '{exam_id:    in_exam_id_i,
                           subject_id: in_subject_id_i,
                           image_id:   in_image_id_i,
                           condition:  in_condition_i,
                           wait_time:  in_wait_time_i};

  // Build the row of slots
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int unsigned L = (i == 0) ? 0 : i - 1;
    localparam int unsigned R = (i == CAPACITY - 1) ? i : i + 1;

    assign occupied[i] = (CntW'(i) < count_q);

    mpq_cell #(
      .PrioBits(PRIORITY_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occupied_i  (occupied[i]),
      .new_prio_i  (new_prio),
      .new_rec_i   (new_rec),
      .left_gt_i   ((i == 0) ? 1'b0 : gt[L]),
      .left_prio_i (prio[L]),
      .left_rec_i  (rec[L]),
      .right_prio_i(prio[R]),
      .right_rec_i (rec[R]),
      .gt_o        (gt[i]),
      .prio_o      (prio[i]),
      .rec_o       (rec[i])
    );
  end

  assign head_prio_wide = {8'd0, prio[0]};

  // Form the result and the next count
  always_comb begin
    count_d    = count_q;
    status_d   = mpq_pkg::STATUS_DONE;
    out_prio_d = '0;
    out_rec_d  = '0;
    if (operation_i == mpq_pkg::OP_INSERT) begin
      if (is_full) begin
        status_d = mpq_pkg::STATUS_FULL;
      end else begin
        count_d = count_q + 1'b1;
      end
    end else begin
      if (is_empty) begin
        status_d = mpq_pkg::STATUS_EMPTY;
      end else begin
        count_d    = count_q - 1'b1;
        out_prio_d = head_prio_wide[7:0];
        out_rec_d  = rec[0];
      end
    end
    occ_wide = {8'd0, count_d};
    occ_d    = occ_wide[7:0];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        count_q <= count_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      status_q   <= status_d;
      out_prio_q <= out_prio_d;
      out_rec_q  <= out_rec_d;
      occ_q      <= occ_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign out_priority_o   = out_prio_q;
  assign out_exam_id_o    = out_rec_q.exam_id;
  assign out_subject_id_o = out_rec_q.subject_id;
  assign out_image_id_o   = out_rec_q.image_id;
  assign out_condition_o  = out_rec_q.condition;
  assign out_wait_time_o  = out_rec_q.wait_time;
  assign occupancy_o      = occ_q;

  // Checks
  `ASSERT_CLK(a_count_bound, clk_i, rst_ni, count_q <= CapCnt)
  `ASSERT_IMPLY(a_full_status, clk_i, rst_ni,
    out_valid_q && status_q == mpq_pkg::STATUS_FULL, count_q == CapCnt)
  `ASSERT_IMPLY(a_empty_status, clk_i, rst_ni,
    out_valid_q && status_q == mpq_pkg::STATUS_EMPTY, count_q == '0)
  `ASSERT_IMPLY(a_insert_grows, clk_i, rst_ni, ctrl.ins,
    ##1 count_q == $past(count_q) + 1'b1)

endmodule

`default_nettype wire
